// ----- rtl/core/twc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twc_pkg
// Shared types and constants of the two-way cache tag controller.
// ----------------------------------------------------------------------------
package twc_pkg;

    localparam int INDEX_BITS_MAX_DEF    = 12;
    localparam int PREDICTOR_ENTRIES_DEF = 4;

    // Tag kept at full address width: small offset plus index leaves up to 32 bits
    localparam int TAG_W   = 32;
    localparam int ADDR_W  = 32;
    localparam int CNT_W   = 32;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Configuration register indexes
    localparam logic [1:0] REG_ASSOC      = 2'd0;
    localparam logic [1:0] REG_CACHE_SIZE = 2'd1;
    localparam logic [1:0] REG_BLOCK      = 2'd2;
    localparam logic [1:0] REG_PREDICT    = 2'd3;

    // Configuration reset values
    localparam logic [1:0] ASSOC_RST      = 2'd2;
    localparam logic [4:0] CACHE_SIZE_RST = 5'd15;
    localparam logic [3:0] BLOCK_RST      = 4'd9;
    localparam logic [1:0] PREDICT_RST    = 2'd0;

    localparam logic [1:0] ASSOC_DIRECT = 2'd1;
    localparam logic       OP_STORE     = 1'b1;

    typedef struct packed {
        logic [1:0] assoc;
        logic [4:0] size_bits;
        logic [3:0] block_bits;
        logic [1:0] predict_bits;
    } cfg_t;

    // One set as stored in the set RAM
    typedef struct packed {
        logic             lru;
        logic             valid1;
        logic             dirty1;
        logic [TAG_W-1:0] tag1;
        logic             valid0;
        logic             dirty0;
        logic [TAG_W-1:0] tag0;
    } row_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic update;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
    } sts_t;

endpackage : twc_pkg
`default_nettype wire

// ----- rtl/core/twc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module twc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule : twc_ram
`default_nettype wire

// ----- rtl/core/twc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twc_ctrl
// Controller: clearing pass after reset, then accept / lookup per word.
// ----------------------------------------------------------------------------
module twc_ctrl (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  wire logic         out_ready,
    input  wire twc_pkg::sts_t sts,
    output twc_pkg::cmd_t     cmd
);
    import twc_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                // hold the read set until the result register frees up
                if (out_free)
                begin
                    cmd.update     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule : twc_ctrl
`default_nettype wire

// ----- rtl/core/twc_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twc_datapath
// Address split, set RAM, tag compare, LRU / dirty / predictor update and
// running counters.
// ----------------------------------------------------------------------------
module twc_datapath #(
    parameter int INDEX_BITS_MAX    = twc_pkg::INDEX_BITS_MAX_DEF,
    parameter int PREDICTOR_ENTRIES = twc_pkg::PREDICTOR_ENTRIES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire twc_pkg::cfg_t                cfg,
    input  wire twc_pkg::cmd_t                cmd,
    output twc_pkg::sts_t                     sts,
    input  wire logic                         operation,
    input  wire logic [twc_pkg::ADDR_W-1:0]   address,
    output logic                              hit,
    output logic                              way_used,
    output logic                              dirty_evict,
    output logic                              mispredict,
    output logic      [twc_pkg::CNT_W-1:0]    hit_count,
    output logic      [twc_pkg::CNT_W-1:0]    miss_count,
    output logic      [twc_pkg::CNT_W-1:0]    store_count,
    output logic      [twc_pkg::CNT_W-1:0]    writeback_count,
    output logic      [twc_pkg::CNT_W-1:0]    mispredict_count
);
    import twc_pkg::*;

    localparam int IDX_W = INDEX_BITS_MAX;
    localparam int SETS  = 1 << IDX_W;
    localparam int IB_W  = $clog2(INDEX_BITS_MAX + 1);
    localparam int PI_W  = (PREDICTOR_ENTRIES > 1) ? $clog2(PREDICTOR_ENTRIES) : 1;
    localparam int ROW_W = $bits(row_t);

    // ---------------- address split ----------------
    logic                two;
    logic signed [6:0]   ib_raw;
    logic [IB_W-1:0]     ib;
    logic [ADDR_W-1:0]   addr_shift;
    logic [IDX_W-1:0]    set_idx;
    logic [5:0]          sh;
    logic [TAG_W-1:0]    tag;
    logic [2:0]          pi_raw;
    logic [4:0]          pi_wrap;

    assign two = (cfg.assoc != ASSOC_DIRECT);

    always_comb
    begin
        ib_raw = $signed({2'b00, cfg.size_bits}) - $signed({3'b000, cfg.block_bits})
                 - $signed({6'b000000, two});
        if (ib_raw < 7'sd0)
        begin
            ib = '0;
        end
        else if (ib_raw > $signed(7'(INDEX_BITS_MAX)))
        begin
            ib = IB_W'(INDEX_BITS_MAX);
        end
        else
        begin
            ib = IB_W'(unsigned'(ib_raw));
        end
    end

    always_comb
    begin
        addr_shift = address >> cfg.block_bits;
        set_idx    = IDX_W'(addr_shift) & ~({IDX_W{1'b1}} << ib);
        sh         = 6'(cfg.block_bits) + 6'(ib);
        tag        = address >> sh;
        pi_raw     = 3'(addr_shift) & ~(3'b111 << cfg.predict_bits);
        // wrap the predictor index into the table
        pi_wrap    = {2'b00, pi_raw};
        for (int i = 0; i < 8; i++)
        begin
            if (pi_wrap >= 5'(PREDICTOR_ENTRIES))
            begin
                pi_wrap = pi_wrap - 5'(PREDICTOR_ENTRIES);
            end
        end
    end

    // ---------------- item registers ----------------
    logic               op_reg;
    logic [IDX_W-1:0]   set_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [PI_W-1:0]    pi_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= operation;
            set_reg <= set_idx;
            tag_reg <= tag;
            pi_reg  <= PI_W'(pi_wrap);
        end
    end

    // ---------------- clearing pass ----------------
    logic [IDX_W-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign sts.clear_last = (clr_addr_reg == {IDX_W{1'b1}});

    // ---------------- set RAM ----------------
    logic [ROW_W-1:0] rdata;
    logic [ROW_W-1:0] wdata;
    logic [IDX_W-1:0] waddr;
    logic             we;
    row_t             cur, nxt;

    assign we    = cmd.clear || cmd.update;
    assign waddr = cmd.clear ? clr_addr_reg : set_reg;
    assign wdata = cmd.clear ? '0 : ROW_W'(nxt);

    twc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_set_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.accept),
        .raddr (set_idx),
        .rdata (rdata)
    );

    // ---------------- lookup ----------------
    logic [PREDICTOR_ENTRIES-1:0] pred_reg;
    logic hit0, hit1;
    logic pred_cur;
    logic res_hit, res_way, res_wb, res_mp;
    logic pred_we;

    always_comb
    begin
        cur      = row_t'(rdata);
        nxt      = cur;
        hit0     = cur.valid0 && (cur.tag0 == tag_reg);
        hit1     = cur.valid1 && (cur.tag1 == tag_reg);
        pred_cur = 1'b0;
        for (int i = 0; i < PREDICTOR_ENTRIES; i++)
        begin
            if (pi_reg == PI_W'(i))
            begin
                pred_cur = pred_reg[i];
            end
        end
        res_hit = 1'b0;
        res_way = 1'b0;
        res_wb  = 1'b0;
        res_mp  = 1'b0;
        pred_we = 1'b0;
        if (!two)
        begin
            res_hit = hit0;
            if (!hit0)
            begin
                nxt.tag0   = tag_reg;
                nxt.valid0 = 1'b1;
            end
        end
        else if (hit0 || hit1)
        begin
            res_hit = 1'b1;
            res_way = !hit0;
            res_mp  = (pred_cur != res_way);
            pred_we = res_mp;
            nxt.lru = !res_way;
            if (op_reg == OP_STORE)
            begin
                if (res_way)
                begin
                    nxt.dirty1 = 1'b1;
                end
                else
                begin
                    nxt.dirty0 = 1'b1;
                end
            end
        end
        else
        begin
            res_way = cur.lru;
            pred_we = 1'b1;
            nxt.lru = !cur.lru;
            if (cur.lru)
            begin
                res_wb     = cur.valid1 && cur.dirty1;
                nxt.tag1   = tag_reg;
                nxt.valid1 = 1'b1;
                nxt.dirty1 = (op_reg == OP_STORE);
            end
            else
            begin
                res_wb     = cur.valid0 && cur.dirty0;
                nxt.tag0   = tag_reg;
                nxt.valid0 = 1'b1;
                nxt.dirty0 = (op_reg == OP_STORE);
            end
        end
    end

    // ---------------- predictor, counters, result ----------------
    logic [CNT_W-1:0] hit_cnt_reg, miss_cnt_reg, store_cnt_reg, wb_cnt_reg, mp_cnt_reg;
    logic             hit_reg, way_reg, wb_reg, mp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_reg      <= PREDICTOR_ENTRIES'(1);
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            store_cnt_reg <= '0;
            wb_cnt_reg    <= '0;
            mp_cnt_reg    <= '0;
        end
        else if (cmd.update)
        begin
            for (int i = 0; i < PREDICTOR_ENTRIES; i++)
            begin
                if (pred_we && (pi_reg == PI_W'(i)))
                begin
                    pred_reg[i] <= res_way;
                end
            end
            hit_cnt_reg   <= hit_cnt_reg   + CNT_W'(res_hit);
            miss_cnt_reg  <= miss_cnt_reg  + CNT_W'(!res_hit);
            store_cnt_reg <= store_cnt_reg + CNT_W'(two && (op_reg == OP_STORE));
            wb_cnt_reg    <= wb_cnt_reg    + CNT_W'(res_wb);
            mp_cnt_reg    <= mp_cnt_reg    + CNT_W'(res_mp);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            hit_reg <= res_hit;
            way_reg <= res_way;
            wb_reg  <= res_wb;
            mp_reg  <= res_mp;
        end
    end

    assign hit              = hit_reg;
    assign way_used         = way_reg;
    assign dirty_evict      = wb_reg;
    assign mispredict       = mp_reg;
    assign hit_count        = hit_cnt_reg;
    assign miss_count       = miss_cnt_reg;
    assign store_count      = store_cnt_reg;
    assign writeback_count  = wb_cnt_reg;
    assign mispredict_count = mp_cnt_reg;

endmodule : twc_datapath
`default_nettype wire

// ----- rtl/core/two_way_cache_tag_lru_predictor.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_way_cache_tag_lru_predictor
// Cache tag controller: direct-mapped or two-way with LRU, write-back dirty
// tracking, a way predictor and running hit / miss / store / write-back /
// mispredict counters.
// ----------------------------------------------------------------------------
// The accept cycle reads the addressed set from the set RAM (one write and
// one read port; both ways, LRU bit, valid and dirty bits in one row); in
// lookup, once the result register is free, the tags are compared and the
// updated row is written back, so one word is in flight at a time. The result
// sits in an output register, so the next word is accepted while a result
// waits; that word then holds in lookup until the result is taken. After
// reset the block runs a clearing pass over all 2**INDEX_BITS_MAX sets (4096
// by default) with in_ready low; register writes over APB are taken
// throughout. Reprogram registers only while no word is in flight.
// ----------------------------------------------------------------------------
module two_way_cache_tag_lru_predictor #(
    parameter int INDEX_BITS_MAX    = twc_pkg::INDEX_BITS_MAX_DEF,
    parameter int PREDICTOR_ENTRIES = twc_pkg::PREDICTOR_ENTRIES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // APB register port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [twc_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [twc_pkg::PDATA_W-1:0]   pwdata,
    output logic      [twc_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready,
    // access channel
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          operation,
    input  wire logic [twc_pkg::ADDR_W-1:0]    address,
    // result channel
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               hit,
    output logic                               way_used,
    output logic                               dirty_evict,
    output logic                               mispredict,
    output logic      [twc_pkg::CNT_W-1:0]     hit_count,
    output logic      [twc_pkg::CNT_W-1:0]     miss_count,
    output logic      [twc_pkg::CNT_W-1:0]     store_count,
    output logic      [twc_pkg::CNT_W-1:0]     writeback_count,
    output logic      [twc_pkg::CNT_W-1:0]     mispredict_count
);
    import twc_pkg::*;

    // ---------------- configuration registers ----------------
    logic [1:0] assoc_reg;
    logic [4:0] size_bits_reg;
    logic [3:0] block_bits_reg;
    logic [1:0] predict_bits_reg;
    logic       cfg_write;
    logic [1:0] reg_sel;
    cfg_t       cfg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            assoc_reg        <= ASSOC_RST;
            size_bits_reg    <= CACHE_SIZE_RST;
            block_bits_reg   <= BLOCK_RST;
            predict_bits_reg <= PREDICT_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_ASSOC:      assoc_reg        <= pwdata[1:0];
                REG_CACHE_SIZE: size_bits_reg    <= pwdata[4:0];
                REG_BLOCK:      block_bits_reg   <= pwdata[3:0];
                REG_PREDICT:    predict_bits_reg <= pwdata[1:0];
                default:        assoc_reg        <= assoc_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_ASSOC:      prdata = PDATA_W'(assoc_reg);
            REG_CACHE_SIZE: prdata = PDATA_W'(size_bits_reg);
            REG_BLOCK:      prdata = PDATA_W'(block_bits_reg);
            REG_PREDICT:    prdata = PDATA_W'(predict_bits_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.assoc        = assoc_reg;
    assign cfg.size_bits    = size_bits_reg;
    assign cfg.block_bits   = block_bits_reg;
    assign cfg.predict_bits = predict_bits_reg;

    // ---------------- controller and datapath ----------------
    cmd_t cmd;
    sts_t sts;

    twc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    twc_datapath #(
        .INDEX_BITS_MAX    (INDEX_BITS_MAX),
        .PREDICTOR_ENTRIES (PREDICTOR_ENTRIES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .cmd              (cmd),
        .sts              (sts),
        .operation        (operation),
        .address          (address),
        .hit              (hit),
        .way_used         (way_used),
        .dirty_evict      (dirty_evict),
        .mispredict       (mispredict),
        .hit_count        (hit_count),
        .miss_count       (miss_count),
        .store_count      (store_count),
        .writeback_count  (writeback_count),
        .mispredict_count (mispredict_count)
    );

    // ---------------- assertions ----------------
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("new word accepted while lookup pending");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> (CNT_W'(hit_count + miss_count) ==
                        CNT_W'($past(hit_count) + $past(miss_count) + 1'b1)))
        else $error("hit plus miss count did not advance by one");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && dirty_evict))
        else $error("dirty eviction reported on a hit");

    a_mp_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(mispredict && !hit))
        else $error("misprediction reported on a miss");

endmodule : two_way_cache_tag_lru_predictor
`default_nettype wire

// ----- tb/tb_two_way_cache_tag_lru_predictor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_way_cache_tag_lru_predictor
// Self-checking bench for the cache tag controller. A clocked driver offers
// load/store words from a pending queue and a clocked monitor runs a local
// tag/LRU/dirty/way-predictor model on every accepted word, then compares
// each accepted result field by field. Several register settings are swept,
// out-of-range ones included, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_two_way_cache_tag_lru_predictor;
    import twc_pkg::*;

    localparam int  SETS        = 1 << INDEX_BITS_MAX_DEF;
    localparam int  WAYPRED_N   = PREDICTOR_ENTRIES_DEF;
    localparam int  PIDX_W      = (WAYPRED_N > 1) ? $clog2(WAYPRED_N) : 1;
    localparam int  STALL_LIMIT = 20000;
    localparam int  LONG_HOLD   = 300;
    localparam logic OP_LOAD    = ~OP_STORE;

    typedef struct packed {
        logic        op;
        logic [31:0] addr;
    } access_t;

    typedef struct packed {
        bit        hit;
        bit        way;
        bit        evict;
        bit        miss_pred;
        bit [31:0] hits;
        bit [31:0] misses;
        bit [31:0] stores;
        bit [31:0] writebacks;
        bit [31:0] mispredicts;
    } access_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 operation = 1'b0;
    logic [ADDR_W-1:0]    address = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 hit;
    logic                 way_used;
    logic                 dirty_evict;
    logic                 mispredict;
    logic [CNT_W-1:0]     hit_count;
    logic [CNT_W-1:0]     miss_count;
    logic [CNT_W-1:0]     store_count;
    logic [CNT_W-1:0]     writeback_count;
    logic [CNT_W-1:0]     mispredict_count;

    two_way_cache_tag_lru_predictor dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operation        (operation),
        .address          (address),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .hit              (hit),
        .way_used         (way_used),
        .dirty_evict      (dirty_evict),
        .mispredict       (mispredict),
        .hit_count        (hit_count),
        .miss_count       (miss_count),
        .store_count      (store_count),
        .writeback_count  (writeback_count),
        .mispredict_count (mispredict_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Shadow of the cache state and registers
    bit [1:0]  assoc_cfg = ASSOC_RST;
    bit [4:0]  size_cfg  = CACHE_SIZE_RST;
    bit [3:0]  block_cfg = BLOCK_RST;
    bit [1:0]  pred_cfg  = PREDICT_RST;
    bit [31:0] tag_way0 [SETS];
    bit [31:0] tag_way1 [SETS];
    bit        valid_way0 [SETS];
    bit        valid_way1 [SETS];
    bit        dirty_way0 [SETS];
    bit        dirty_way1 [SETS];
    bit        lru_victim [SETS];
    bit        way_table [WAYPRED_N];
    bit [31:0] hits_total, misses_total, stores_total, writebacks_total, mispredicts_total;

    access_t        pending_accesses [$];
    access_result_t expected_results [$];
    int unsigned    offered_cnt = 0;
    int unsigned    taken_cnt = 0;
    int unsigned    hold_requests = 0;
    int unsigned    holds_started = 0;
    int             hold_left = 0;
    bit             steady = 1'b0;
    int unsigned    errors = 0;
    int unsigned    quiet_cycles = 0;

    function automatic int index_width();
        int ib;
        ib = int'(size_cfg) - int'(block_cfg) - ((assoc_cfg != ASSOC_DIRECT) ? 1 : 0);
        if (ib < 0)
            ib = 0;
        if (ib > INDEX_BITS_MAX_DEF)
            ib = INDEX_BITS_MAX_DEF;
        return ib;
    endfunction

    function automatic access_result_t lookup_and_update(logic op, logic [31:0] addr);
        access_result_t                r;
        bit                            is_store;
        int                            ib;
        bit [INDEX_BITS_MAX_DEF-1:0]   set_idx;
        bit [PIDX_W-1:0]               pidx;
        bit [31:0]                     tag;
        r = '0;
        is_store = (op == OP_STORE);
        ib = index_width();
        set_idx = INDEX_BITS_MAX_DEF'((addr >> block_cfg) & ((32'd1 << ib) - 1));
        tag = addr >> (block_cfg + ib);
        if (assoc_cfg == ASSOC_DIRECT)
        begin
            if (valid_way0[set_idx] && tag_way0[set_idx] == tag)
                r.hit = 1'b1;
            else
            begin
                tag_way0[set_idx] = tag;
                valid_way0[set_idx] = 1'b1;
            end
        end
        else
        begin
            pidx = PIDX_W'(((addr >> block_cfg) & ((32'd1 << pred_cfg) - 1)) % WAYPRED_N);
            if (is_store)
                stores_total++;
            if (valid_way0[set_idx] && tag_way0[set_idx] == tag)
                r.hit = 1'b1;
            else if (valid_way1[set_idx] && tag_way1[set_idx] == tag)
            begin
                r.hit = 1'b1;
                r.way = 1'b1;
            end
            if (r.hit)
            begin
                if (way_table[pidx] != r.way)
                begin
                    r.miss_pred = 1'b1;
                    way_table[pidx] = r.way;
                end
                lru_victim[set_idx] = ~r.way;
                if (is_store)
                begin
                    if (r.way)
                        dirty_way1[set_idx] = 1'b1;
                    else
                        dirty_way0[set_idx] = 1'b1;
                end
            end
            else
            begin
                // fill the LRU way, write back if it held a dirty line
                r.way = lru_victim[set_idx];
                way_table[pidx] = r.way;
                lru_victim[set_idx] = ~r.way;
                if (r.way)
                begin
                    r.evict = valid_way1[set_idx] && dirty_way1[set_idx];
                    tag_way1[set_idx] = tag;
                    valid_way1[set_idx] = 1'b1;
                    dirty_way1[set_idx] = is_store;
                end
                else
                begin
                    r.evict = valid_way0[set_idx] && dirty_way0[set_idx];
                    tag_way0[set_idx] = tag;
                    valid_way0[set_idx] = 1'b1;
                    dirty_way0[set_idx] = is_store;
                end
            end
        end
        if (r.hit)
            hits_total++;
        else
            misses_total++;
        if (r.evict)
            writebacks_total++;
        if (r.miss_pred)
            mispredicts_total++;
        r.hits = hits_total;
        r.misses = misses_total;
        r.stores = stores_total;
        r.writebacks = writebacks_total;
        r.mispredicts = mispredicts_total;
        return r;
    endfunction

    task automatic check_field(input string name, input bit [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // Driver: offer pending words, hold each until taken
    always @(negedge clk)
    begin : access_driver
        access_t next_word;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && taken_cnt != offered_cnt)
        begin
        end
        else if (pending_accesses.size() != 0 && (steady || $urandom_range(0, 99) >= 35))
        begin
            next_word = pending_accesses.pop_front();
            in_valid <= 1'b1;
            operation <= next_word.op;
            address <= next_word.addr;
            offered_cnt++;
        end
        else
            in_valid <= 1'b0;
    end

    // Receiver: random back-pressure plus requested long holds
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (holds_started != hold_requests)
        begin
            holds_started++;
            hold_left = LONG_HOLD;
            out_ready <= 1'b0;
        end
        else if (steady)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) >= 35);
    end

    // Monitor: check results, predict accepted words, track register writes
    always @(posedge clk)
    begin : result_monitor
        access_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word with no access outstanding");
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("hit", 32'(want.hit), 32'(hit));
                    check_field("way_used", 32'(want.way), 32'(way_used));
                    check_field("dirty_evict", 32'(want.evict), 32'(dirty_evict));
                    check_field("mispredict", 32'(want.miss_pred), 32'(mispredict));
                    check_field("hit_count", want.hits, hit_count);
                    check_field("miss_count", want.misses, miss_count);
                    check_field("store_count", want.stores, store_count);
                    check_field("writeback_count", want.writebacks, writeback_count);
                    check_field("mispredict_count", want.mispredicts, mispredict_count);
                end
            end
            if (in_valid && in_ready)
            begin
                expected_results.push_back(lookup_and_update(operation, address));
                taken_cnt++;
            end
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00)
            begin
                case (paddr[3:2])
                    REG_ASSOC:      assoc_cfg = pwdata[1:0];
                    REG_CACHE_SIZE: size_cfg  = pwdata[4:0];
                    REG_BLOCK:      block_cfg = pwdata[3:0];
                    REG_PREDICT:    pred_cfg  = pwdata[1:0];
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic queue_access(input logic op, input logic [31:0] addr);
        access_t a;
        a.op = op;
        a.addr = addr;
        pending_accesses.push_back(a);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Junk in the upper data bits must be dropped by the register
    task automatic set_config(input bit [1:0] a, input bit [4:0] s, input bit [3:0] b,
                              input bit [1:0] p);
        write_reg(REG_ASSOC, ($urandom << 2) | a);
        write_reg(REG_CACHE_SIZE, ($urandom << 5) | s);
        write_reg(REG_BLOCK, ($urandom << 4) | b);
        write_reg(REG_PREDICT, ($urandom << 2) | p);
    endtask

    task automatic wait_drain();
        while (pending_accesses.size() != 0 || taken_cnt != offered_cnt ||
               expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly words drawn from a few tags over a few sets so that lines
    // collide, hit, go dirty and get evicted; the rest fully random.
    task automatic random_phase(input bit [1:0] a, input bit [4:0] s, input bit [3:0] b,
                                input bit [1:0] p, input int n_items, input bit no_idle,
                                input bit long_hold);
        bit [31:0] tag_hi [6];
        bit [31:0] set_bits [4];
        bit [31:0] off_mask;
        bit [31:0] set_mask;
        int        sh;
        set_config(a, s, b, p);
        sh = block_cfg + index_width();
        off_mask = (32'd1 << block_cfg) - 1;
        set_mask = (32'd1 << index_width()) - 1;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 48 == 0)
            begin
                foreach (tag_hi[k])
                    tag_hi[k] = (k == 0) ? 32'd0 : ($urandom & ~((32'd1 << sh) - 1));
                foreach (set_bits[k])
                    set_bits[k] = ($urandom & set_mask) << block_cfg;
            end
            if ($urandom_range(0, 99) < 80)
                queue_access(1'($urandom_range(0, 1)),
                             tag_hi[$urandom_range(0, 5)] | set_bits[$urandom_range(0, 3)] |
                             ($urandom & off_mask));
            else
                queue_access(1'($urandom_range(0, 1)), $urandom);
        end
        steady = no_idle;
        if (long_hold)
            hold_requests++;
        wait_drain();
        steady = 1'b0;
    endtask

    initial
    begin
        foreach (way_table[k])
            way_table[k] = (k == 0);
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // default two-way setting: 512-byte blocks, 32 sets
        queue_access(OP_LOAD,  32'h0000_0000);
        queue_access(OP_LOAD,  32'h0000_01FF);
        queue_access(OP_STORE, 32'h0000_4000);
        queue_access(OP_LOAD,  32'h0000_0000);
        queue_access(OP_STORE, 32'h0000_0000);
        queue_access(OP_STORE, 32'h0000_4004);
        queue_access(OP_LOAD,  32'h0000_8000);
        queue_access(OP_LOAD,  32'h0000_C000);
        queue_access(OP_LOAD,  32'hFFFF_FFFF);
        queue_access(OP_STORE, 32'hFFFF_FE00);
        queue_access(OP_STORE, 32'h8000_0000);
        queue_access(OP_LOAD,  32'h7FFF_FFFF);
        queue_access(OP_LOAD,  32'h5555_5555);
        queue_access(OP_STORE, 32'hAAAA_AAAA);
        wait_drain();

        // direct mapped: refill of one set
        set_config(ASSOC_DIRECT, 5'd12, 4'd4, 2'd0);
        queue_access(OP_STORE, 32'h0000_0010);
        queue_access(OP_LOAD,  32'h0000_0010);
        queue_access(OP_LOAD,  32'h0000_1010);
        queue_access(OP_LOAD,  32'h0000_0010);
        queue_access(OP_STORE, 32'hFFFF_FFF0);
        wait_drain();

        // clamped index width, predictor index wrapping past the table
        set_config(2'd3, 5'd24, 4'd2, 2'd3);
        queue_access(OP_LOAD,  32'h0000_0010);
        queue_access(OP_LOAD,  32'h0000_001C);
        queue_access(OP_LOAD,  32'h0000_0010);
        queue_access(OP_STORE, 32'h0000_001C);
        wait_drain();

        random_phase(2'd2, 5'd15, 4'd9, 2'd0, 175, 1'b0, 1'b0);
        random_phase(ASSOC_DIRECT, 5'd12, 4'd4, 2'd1, 175, 1'b0, 1'b0);
        random_phase(2'd2, 5'd6, 4'd2, 2'd2, 175, 1'b1, 1'b0);
        random_phase(2'd3, 5'd24, 4'd2, 2'd3, 175, 1'b0, 1'b1);
        random_phase(2'd0, 5'd3, 4'd12, 2'd1, 175, 1'b0, 1'b0);
        random_phase(ASSOC_DIRECT, 5'd31, 4'd15, 2'd2, 175, 1'b0, 1'b0);
        random_phase(2'd2, 5'd0, 4'd0, 2'd0, 175, 1'b0, 1'b0);
        random_phase(2'd2, 5'd14, 4'd0, 2'd3, 175, 1'b0, 1'b1);
        random_phase(ASSOC_DIRECT, 5'd3, 4'd2, 2'd0, 175, 1'b0, 1'b0);
        random_phase(2'd2, 5'd15, 4'd9, 2'd0, 175, 1'b0, 1'b0);

        repeat (10) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- two_way_cache_tag_lru_predictor.f -----
rtl/core/twc_pkg.sv
rtl/core/twc_ram.sv
rtl/core/twc_ctrl.sv
rtl/core/twc_datapath.sv
rtl/core/two_way_cache_tag_lru_predictor.sv
tb/tb_two_way_cache_tag_lru_predictor.sv
